// ===== rtl/bb3_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 box blur core.
package bb3_pkg;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam logic [10:0] RESET_WIDTH  = 11'd640;
	localparam logic [11:0] RESET_HEIGHT = 12'd480;

	// register indexes of the configuration port
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;

	// reciprocals of 3 and 9 scaled by 2^15, exact for dividends below 2^12
	localparam logic [13:0] RECIP3      = 14'd10923;
	localparam logic [13:0] RECIP9      = 14'd3641;
	localparam int          RECIP_SHIFT = 15;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_PICK,
		S_SUM,
		S_MUL,
		S_OUT
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       shift;
		logic       sum;
		logic       mul;
		logic       load_out;
		logic [1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic [3:0] combo_valid;
		logic       out_free;
	} status_t;

endpackage

// ===== rtl/bb3_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences capture, window update and result emission.
module bb3_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bb3_pkg::status_t st,
	output bb3_pkg::cmd_t    cmd
);

	bb3_pkg::state_t state_q, state_d;
	logic [1:0] idx_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bb3_pkg::S_IDLE: begin
				if (in_valid) state_d = bb3_pkg::S_LOAD;
			end
			bb3_pkg::S_LOAD: state_d = bb3_pkg::S_PICK;
			bb3_pkg::S_PICK: begin
				if (st.combo_valid[idx_q]) state_d = bb3_pkg::S_SUM;
				else if (idx_q == 2'd3) state_d = bb3_pkg::S_IDLE;
			end
			bb3_pkg::S_SUM: state_d = bb3_pkg::S_MUL;
			bb3_pkg::S_MUL: state_d = bb3_pkg::S_OUT;
			bb3_pkg::S_OUT: begin
				if (st.out_free) begin
					state_d = (idx_q == 2'd3) ? bb3_pkg::S_IDLE : bb3_pkg::S_PICK;
				end
			end
			default: state_d = bb3_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		cmd.idx = idx_q;
		case (state_q)
			bb3_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			bb3_pkg::S_LOAD: cmd.shift = 1'b1;
			bb3_pkg::S_PICK: ;
			bb3_pkg::S_SUM: cmd.sum = 1'b1;
			bb3_pkg::S_MUL: cmd.mul = 1'b1;
			bb3_pkg::S_OUT: cmd.load_out = st.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bb3_pkg::S_IDLE;
			idx_q <= 2'd0;
		end else begin
			state_q <= state_d;
			case (state_q)
				bb3_pkg::S_LOAD: idx_q <= 2'd0;
				bb3_pkg::S_PICK: begin
					if (!st.combo_valid[idx_q] && idx_q != 2'd3) idx_q <= idx_q + 2'd1;
				end
				bb3_pkg::S_OUT: begin
					if (st.out_free && idx_q != 2'd3) idx_q <= idx_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/bb3_dp.sv =====
`timescale 1ns / 1ps
// Datapath: line stores, 3x3 window, position counters, averaging and output register.
module bb3_dp #(
	parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [23:0]      px_in,
	input  bb3_pkg::cmd_t    cmd,
	output bb3_pkg::status_t st,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [11:0]      cfg_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [47:0]      out_data,
	output logic             out_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic [23:0] older_mem [MAX_WIDTH];
	logic [23:0] newer_mem [MAX_WIDTH];
	logic [23:0] old_rd_q, new_rd_q, px_q;
	logic [23:0] win_q [3][3];

	logic [10:0] fw_q;
	logic [11:0] fh_q;
	logic [WW-1:0] eff_w;
	logic [11:0] eff_h;
	logic [11:0] row_q, er_q;
	logic [CW-1:0] col_q, ec_q;

	// summing stage
	logic [11:0] r_sel;
	logic [CW-1:0] c_sel;
	logic [2:0] rm, cm;
	logic [1:0] na, nb;
	logic [3:0] dv;
	logic [1:0] sh, n3;
	logic [11:0] sum [3];
	logic [11:0] y [3];
	logic [12:0] xv;
	logic [11:0] y_s1 [3];
	logic [1:0] n3_s1;
	logic [11:0] r_s1;
	logic [CW-1:0] c_s1;

	// multiply stage
	logic [25:0] prod_s2 [3];
	logic [11:0] y_s2 [3];
	logic [1:0] n3_s2;
	logic [11:0] r_s2;
	logic [CW-1:0] c_s2;
	logic [13:0] recip;

	logic [7:0] q [3];
	logic [31:0] c_wide;
	logic fend;
	logic full_q;
	logic [47:0] data_q;
	logic last_q;

	always_comb begin
		if (fw_q == 11'd0) eff_w = WW'(1);
		else if (32'(fw_q) > 32'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
		else eff_w = WW'(fw_q);
		eff_h = (fh_q == 12'd0) ? 12'd1 : fh_q;
	end

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= bb3_pkg::RESET_WIDTH;
			fh_q <= bb3_pkg::RESET_HEIGHT;
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_we && (cfg_idx == bb3_pkg::REG_WIDTH || cfg_idx == bb3_pkg::REG_HEIGHT)) begin
			if (cfg_idx == bb3_pkg::REG_WIDTH) fw_q <= cfg_data[10:0];
			else fh_q <= cfg_data;
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.shift) begin
			if (WW'(ec_q) + WW'(1) < eff_w) begin
				col_q <= ec_q + CW'(1);
			end else begin
				col_q <= '0;
				row_q <= ({1'b0, er_q} + 13'd1 < {1'b0, eff_h}) ? er_q + 12'd1 : 12'd0;
			end
		end
	end

	// line stores
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			old_rd_q <= older_mem[col_q];
			new_rd_q <= newer_mem[col_q];
		end
		if (cmd.shift) begin
			older_mem[ec_q] <= new_rd_q;
			newer_mem[ec_q] <= px_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q <= px_in;
			er_q <= row_q;
			ec_q <= col_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) win_q[k][j] <= '0;
			end
		end else if (cmd.shift) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= old_rd_q;
			win_q[1][2] <= new_rd_q;
			win_q[2][2] <= px_q;
		end
	end

	// combo order: {row is current, col is current}
	always_comb begin
		logic ra, rb, ca, cb;
		ra = (er_q != 12'd0);
		rb = (er_q == eff_h - 12'd1);
		ca = (ec_q != '0);
		cb = (WW'(ec_q) == eff_w - WW'(1));
		st.combo_valid = {rb & cb, rb & ca, ra & cb, ra & ca};
		st.out_free = !full_q || out_ready;
	end

	// window masks, divisor and clipped sums
	always_comb begin
		r_sel = cmd.idx[1] ? er_q : er_q - 12'd1;
		c_sel = cmd.idx[0] ? ec_q : ec_q - CW'(1);
		rm = cmd.idx[1] ? {1'b1, er_q != 12'd0, 1'b0} : {2'b11, er_q >= 12'd2};
		cm = cmd.idx[0] ? {1'b1, ec_q != '0, 1'b0} : {2'b11, ec_q >= CW'(2)};
		na = 2'(rm[0]) + 2'(rm[1]) + 2'(rm[2]);
		nb = 2'(cm[0]) + 2'(cm[1]) + 2'(cm[2]);
		dv = {2'b00, na} * {2'b00, nb};
		sh = 2'd1 + 2'(na == 2'd2) + 2'(nb == 2'd2);
		n3 = 2'(na == 2'd3) + 2'(nb == 2'd3);
		for (int ch = 0; ch < 3; ch++) begin
			sum[ch] = '0;
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					if (rm[k] && cm[j]) sum[ch] = sum[ch] + 12'(win_q[k][j][8*ch +: 8]);
				end
			end
		end
		for (int ch = 0; ch < 3; ch++) begin
			xv = {sum[ch], 1'b0} + 13'(dv);
			y[ch] = 12'(xv >> sh);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			y_s1 <= y;
			n3_s1 <= n3;
			r_s1 <= r_sel;
			c_s1 <= c_sel;
		end
	end

	assign recip = (n3_s1 == 2'd2) ? bb3_pkg::RECIP9 : bb3_pkg::RECIP3;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			for (int ch = 0; ch < 3; ch++) prod_s2[ch] <= 26'(y_s1[ch]) * 26'(recip);
			y_s2 <= y_s1;
			n3_s2 <= n3_s1;
			r_s2 <= r_s1;
			c_s2 <= c_s1;
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			q[ch] = (n3_s2 == 2'd0) ? y_s2[ch][7:0]
				: prod_s2[ch][bb3_pkg::RECIP_SHIFT +: 8];
		end
		c_wide = 32'(c_s2);
		fend = (r_s2 == eff_h - 12'd1) && (WW'(c_s2) == eff_w - WW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (cmd.load_out) begin
			full_q <= 1'b1;
		end else if (out_ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			data_q <= {2'b00, q[2], q[1], q[0], c_wide[9:0], r_s2};
			last_q <= fend;
		end
	end

	assign out_valid = full_q;
	assign out_data = data_q;
	assign out_last = last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && full_q) |-> out_ready)
		else $error("result register overwritten before it was taken");
	a_shift_after_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> $past(cmd.capture))
		else $error("window update without a captured pixel");
	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(col_q) < eff_w)
		else $error("column position outside the frame");

endmodule

// ===== rtl/box_blur_3x3_clamped_border_core.sv =====
`timescale 1ns / 1ps
// A pixel request is taken in S_IDLE and the window updates in the next cycle; then each
// combination of finished row and column is checked in S_PICK, then summed, divided and loaded
// in S_SUM, S_MUL, S_OUT by the single shared averager before the next pixel (0 to 4 results each).
// Results wait in an output register, so the next pixel is taken while one is still pending.
// Reset is asynchronous: frame 640x480, position (0,0), window cleared; line stores keep contents.
// Top level of the 3x3 box blur with clipped border windows.
module box_blur_3x3_clamped_border_core #(
	parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // blue[7:0], green[15:8], red[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // out_row[11:0], out_col[21:12], blur_blue[29:22],
	                              // blur_green[37:30], blur_red[45:38], zero[47:46]
	output logic        m_tlast,  // frame_end
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [11:0] cfg_data
);

	bb3_pkg::cmd_t cmd;
	bb3_pkg::status_t st;

	bb3_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	bb3_dp #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.px_in     (s_tdata),
		.cmd       (cmd),
		.st        (st),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 box blur core: directed frames, then random frames.
module tb_top;

	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;
	localparam int LINE_DEPTH  = 1024;
	localparam int DRAIN_WAIT  = 40;
	localparam int LONG_HOLD   = 400;

	typedef struct {
		logic [11:0] row;
		logic [9:0]  col;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic        last;
	} blur_px_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic [11:0] cfg_data = '0;

	// predictor state
	logic [10:0] pred_width = bb3_pkg::RESET_WIDTH;
	logic [11:0] pred_height = bb3_pkg::RESET_HEIGHT;
	logic [23:0] older_px [LINE_DEPTH];
	logic [23:0] newer_px [LINE_DEPTH];
	logic [23:0] win [3][3];
	int          row_pos = 0;
	int          col_pos = 0;

	blur_px_t    blur_q[$];
	int          fail_cnt = 0;
	int          sent_cnt = 0;
	bit          idle_on = 1'b1;
	bit          long_hold = 1'b0;

	box_blur_3x3_clamped_border_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	initial begin
		#50_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic expect_blur(input int r, input int c, input int rr_now, input int cc_now,
			input int w, input int h);
		int r0, r1, c0, c1, d, rr, cc;
		int sum [3];
		logic [23:0] px;
		blur_px_t e;
		r0 = r > 0 ? r - 1 : 0;
		r1 = r + 1 < h ? r + 1 : h - 1;
		c0 = c > 0 ? c - 1 : 0;
		c1 = c + 1 < w ? c + 1 : w - 1;
		d = (r1 - r0 + 1) * (c1 - c0 + 1);
		sum = '{0, 0, 0};
		for (rr = r0; rr <= r1; rr++)
			for (cc = c0; cc <= c1; cc++) begin
				px = win[(rr + 2 - rr_now) % 3][(cc + 2 - cc_now) % 3];
				sum[0] += px[7:0];
				sum[1] += px[15:8];
				sum[2] += px[23:16];
			end
		e.row   = r[11:0];
		e.col   = c[9:0];
		e.blue  = 8'((2 * sum[0] + d) / (2 * d));
		e.green = 8'((2 * sum[1] + d) / (2 * d));
		e.red   = 8'((2 * sum[2] + d) / (2 * d));
		e.last  = (r == h - 1) && (c == w - 1);
		blur_q.push_back(e);
	endtask

	task automatic blur_pixel(input logic [23:0] px);
		int w, h, r, c, i, j, nr, nc;
		int rows [2];
		int cols [2];
		w = pred_width == 0 ? 1 : (pred_width > LINE_DEPTH ? LINE_DEPTH : int'(pred_width));
		h = pred_height == 0 ? 1 : int'(pred_height);
		r = row_pos >= h ? 0 : row_pos;
		c = col_pos >= w ? 0 : col_pos;
		for (i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = older_px[c];
		win[1][2] = newer_px[c];
		win[2][2] = px;
		older_px[c] = newer_px[c];
		newer_px[c] = px;
		nr = 0;
		nc = 0;
		if (r >= 1) begin
			rows[nr] = r - 1;
			nr++;
		end
		if (r == h - 1) begin
			rows[nr] = r;
			nr++;
		end
		if (c >= 1) begin
			cols[nc] = c - 1;
			nc++;
		end
		if (c == w - 1) begin
			cols[nc] = c;
			nc++;
		end
		for (i = 0; i < nr; i++)
			for (j = 0; j < nc; j++)
				expect_blur(rows[i], cols[j], r, c, w, h);
		if (c + 1 < w) begin
			col_pos = c + 1;
			row_pos = r;
		end else begin
			col_pos = 0;
			row_pos = r + 1 < h ? r + 1 : 0;
		end
	endtask

	task automatic send_pixel(input logic [23:0] px);
		int gap;
		gap = idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		blur_pixel(px);
		sent_cnt++;
	endtask

	function automatic logic [23:0] rand_px();
		case ($urandom_range(0, 7))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	// wait for the block to go quiet, then write one register
	task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
		s_tvalid <= 1'b0;
		while (blur_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bb3_pkg::REG_WIDTH) begin
			pred_width = val[10:0];
		end else if (idx == bb3_pkg::REG_HEIGHT) begin
			pred_height = val;
		end
		if (idx == bb3_pkg::REG_WIDTH || idx == bb3_pkg::REG_HEIGHT) begin
			row_pos = 0;
			col_pos = 0;
		end
	endtask

	task automatic set_frame(input logic [11:0] w, input logic [11:0] h);
		write_reg(bb3_pkg::REG_WIDTH, w);
		write_reg(bb3_pkg::REG_HEIGHT, h);
	endtask

	task automatic send_frame(input int n);
		repeat (n) send_pixel(rand_px());
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = idle_on ? $urandom_range(0, 12) : 0;
			if (long_hold) begin
				gap = LONG_HOLD;
				long_hold = 1'b0;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		blur_px_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (blur_q.size() == 0) begin
				$error("result with no request pending: %h", m_tdata);
				fail_cnt++;
			end else begin
				e = blur_q.pop_front();
				if (m_tdata[11:0] !== e.row) begin
					$error("out_row expected %0d got %0d", e.row, m_tdata[11:0]);
					fail_cnt++;
				end
				if (m_tdata[21:12] !== e.col) begin
					$error("out_col expected %0d got %0d", e.col, m_tdata[21:12]);
					fail_cnt++;
				end
				if (m_tdata[29:22] !== e.blue) begin
					$error("blur_blue expected %0d got %0d", e.blue, m_tdata[29:22]);
					fail_cnt++;
				end
				if (m_tdata[37:30] !== e.green) begin
					$error("blur_green expected %0d got %0d", e.green, m_tdata[37:30]);
					fail_cnt++;
				end
				if (m_tdata[45:38] !== e.red) begin
					$error("blur_red expected %0d got %0d", e.red, m_tdata[45:38]);
					fail_cnt++;
				end
				if (m_tlast !== e.last) begin
					$error("frame_end expected %0d got %0d", e.last, m_tlast);
					fail_cnt++;
				end
			end
		end
	end

	task automatic test_reset_frame();
		send_frame(8);
	endtask

	task automatic test_single_pixel();
		set_frame(12'd1, 12'd1);
		send_pixel(24'h000000);
		send_pixel(24'hFFFFFF);
		send_pixel(24'hAA55AA);
	endtask

	task automatic test_extreme_values();
		set_frame(12'd3, 12'd3);
		repeat (9) send_pixel(24'hFFFFFF);
		repeat (9) send_pixel(24'h000000);
		send_frame(9);
	endtask

	task automatic test_zero_size();
		set_frame(12'd0, 12'd0);
		send_frame(2);
	endtask

	task automatic test_ignored_index();
		set_frame(12'd4, 12'd3);
		send_frame(5);
		write_reg(REG_SPARE_A, 12'd7);
		write_reg(REG_SPARE_B, 12'hFFF);
		send_frame(7);
	endtask

	task automatic test_max_width();
		// width field saturates to the line store depth
		set_frame(12'hFFF, 12'd1);
		idle_on = 1'b0;
		send_frame(6);
		idle_on = 1'b1;
		set_frame(12'd1024, 12'd2);
		send_frame(3);
	endtask

	task automatic test_tall_frame();
		set_frame(12'd2, 12'd4095);
		send_frame(20);
	endtask

	task automatic test_backpressure();
		set_frame(12'd6, 12'd4);
		long_hold = 1'b1;
		send_frame(24);
	endtask

	task automatic test_random_frames();
		int w, h, n, target;
		target = sent_cnt + 300;
		while (sent_cnt < target) begin
			w = $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			idle_on = $urandom_range(0, 3) != 0;
			set_frame(12'(w), 12'(h));
			n = ($urandom_range(0, 6) == 0) ? $urandom_range(1, w * h) : w * h;
			send_frame(n);
			if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE_A, 12'($urandom));
		end
		idle_on = 1'b1;
	endtask

	initial begin
		for (int i = 0; i < LINE_DEPTH; i++) begin
			older_px[i] = '0;
			newer_px[i] = '0;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				win[i][j] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_frame();
		test_single_pixel();
		test_extreme_values();
		test_zero_size();
		test_ignored_index();
		test_max_width();
		test_tall_frame();
		test_backpressure();
		test_random_frames();
		s_tvalid <= 1'b0;
		while (blur_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bb3_pkg.sv
rtl/bb3_ctrl.sv
rtl/bb3_dp.sv
rtl/box_blur_3x3_clamped_border_core.sv
tb/sv/tb_top.sv
